FILE: hdl/range_max_segment_tree_assert.svh
// Assertion macros used by the segment tree back end.
`ifndef RANGE_MAX_SEGMENT_TREE_ASSERT_SVH
`define RANGE_MAX_SEGMENT_TREE_ASSERT_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define RMST_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("rmst assertion failed");
// Check that an antecedent implies a consequent in the same cycle.
`define RMST_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmst implication failed");
// Check that an antecedent implies a consequent in the next cycle.
`define RMST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmst next-cycle check failed");
`else
`define RMST_ASSERT(label, cond)
`define RMST_ASSERT_IMP(label, ante, cons)
`define RMST_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: hdl/rmst_pkg.sv
// Shared types and constants of the range maximum segment tree.
package rmst_pkg;

  localparam int POS_W = 10;
  localparam int END_W = 11;
  localparam int VAL_W = 31;
  localparam int QDEPTH = 2;

  // Request kind codes as carried on in_tuser
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_QUERY,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] position;
    logic [END_W-1:0] range_end;
    logic [VAL_W-1:0] value;
  } cmd_t;

  // Status of the back end seen by the front
  typedef struct packed {
    logic clearing;
  } back_stat_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_UP_RD,
    ST_UP_WR,
    ST_Q_LO,
    ST_Q_HI,
    ST_EMIT
  } state_t;

endpackage

FILE: hdl/rmst_front.sv
// Front end: accepts requests, drops ignored writes and flags bad ranges.
module rmst_front #(
  parameter int LEAVES = 1024
) (
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [55:0]               in_tdata,
  input  logic                      in_tuser,
  input  logic                      q_full,
  input  rmst_pkg::back_stat_t      stat,
  output logic                      q_push,
  output rmst_pkg::cmd_t            q_cmd
);

  logic [rmst_pkg::POS_W-1:0] pos;
  logic [rmst_pkg::END_W-1:0] rend;
  logic [rmst_pkg::VAL_W-1:0] val;
  logic                       wr_drop;
  logic                       q_bad;
  logic                       accept;

  // Unpack the request fields
  assign pos  = in_tdata[9:0];
  assign rend = in_tdata[20:10];
  assign val  = in_tdata[51:21];

  // Hold off requests while the queue is full or the tree is clearing
  assign in_tready = !q_full && !stat.clearing;
  assign accept    = in_tvalid && in_tready;

  // Classify: out-of-range writes vanish, bad queries carry a flag
  assign wr_drop = {22'd0, pos} >= 32'(LEAVES);
  assign q_bad   = ({1'b0, pos} >= rend) || ({21'd0, rend} > 32'(LEAVES));

  always_comb begin
    q_cmd.position  = pos;
    q_cmd.range_end = rend;
    q_cmd.value     = val;
    q_push          = 1'b0;
    if (in_tuser == rmst_pkg::KIND_WRITE) begin
      q_cmd.op = rmst_pkg::OP_WRITE;
      q_push   = accept && !wr_drop && rst_n;
    end else begin
      q_cmd.op = q_bad ? rmst_pkg::OP_BAD : rmst_pkg::OP_QUERY;
      q_push   = accept && rst_n;
    end
  end

endmodule

FILE: hdl/rmst_fifo.sv
// Short request queue between front and back ends.
module rmst_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rmst_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output rmst_pkg::cmd_t head_cmd,
  output logic           empty
);

  localparam int PW = (rmst_pkg::QDEPTH > 1) ? $clog2(rmst_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(rmst_pkg::QDEPTH + 1);

  rmst_pkg::cmd_t entry_r [rmst_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full     = count_r == CW'(rmst_pkg::QDEPTH);
  assign empty    = count_r == '0;
  assign head_cmd = entry_r[rd_ptr_r];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push && !full) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(rmst_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop && !empty) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(rmst_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if ((push && !full) && !(pop && !empty)) begin
      count_nxt = count_r + CW'(1);
    end else if (!(push && !full) && (pop && !empty)) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: hdl/rmst_back.sv
// Back end: tree memory, update climb, range query walk and result register.
`include "range_max_segment_tree_assert.svh"
module rmst_back #(
  parameter int LEAVES = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rmst_pkg::cmd_t        q_cmd,
  input  logic                  q_empty,
  output logic                  q_pop,
  output rmst_pkg::back_stat_t  stat,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,
  output logic                  out_tuser
);

  localparam int PAD   = 1 << $clog2(LEAVES);
  localparam int PW    = $clog2(PAD);
  localparam int AW    = PW + 1;
  localparam int IW    = PW + 2;
  localparam int DEPTH = 2 * PAD;
  localparam int VW    = rmst_pkg::VAL_W;

  rmst_pkg::state_t state_r, state_nxt;

  logic [VW-1:0] mem [DEPTH];
  logic [VW-1:0] rdata_r;

  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [VW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] lo_r, lo_nxt;
  logic [IW-1:0] hi_r, hi_nxt;
  logic [VW-1:0] best_r, best_nxt;
  logic          pend_r, pend_nxt;
  logic          bad_r, bad_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [VW-1:0] out_max_r, out_max_nxt;
  logic          out_bad_r, out_bad_nxt;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;

  logic [IW-1:0] leaf_idx;
  logic [IW-1:0] q_lo;
  logic [IW-1:0] q_hi;
  logic [VW-1:0] up_max;
  logic [VW-1:0] acc;
  logic [IW-1:0] hi_dec;
  logic          out_free;

  assign leaf_idx = IW'(q_cmd.position) + IW'(PAD);
  assign q_lo     = IW'(q_cmd.position) + IW'(PAD);
  assign q_hi     = IW'(q_cmd.range_end) + IW'(PAD);
  assign up_max   = (rdata_r > cur_r) ? rdata_r : cur_r;
  assign acc      = (pend_r && (rdata_r > best_r)) ? rdata_r : best_r;
  assign hi_dec   = hi_r - IW'(1);
  assign out_free = !out_valid_r || out_tready;

  assign stat.clearing = state_r == rmst_pkg::ST_CLR;
  assign q_pop         = (state_r == rmst_pkg::ST_IDLE) && !q_empty;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_max_r};
  assign out_tuser  = out_bad_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rmst_pkg::ST_CLR: begin
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = rmst_pkg::ST_IDLE;
        end
      end
      rmst_pkg::ST_IDLE: begin
        if (!q_empty) begin
          unique case (q_cmd.op)
            rmst_pkg::OP_WRITE: begin
              state_nxt = (leaf_idx == IW'(1)) ? rmst_pkg::ST_IDLE : rmst_pkg::ST_UP_RD;
            end
            rmst_pkg::OP_QUERY: state_nxt = rmst_pkg::ST_Q_LO;
            default:            state_nxt = rmst_pkg::ST_EMIT;
          endcase
        end
      end
      rmst_pkg::ST_UP_RD: state_nxt = rmst_pkg::ST_UP_WR;
      rmst_pkg::ST_UP_WR: begin
        state_nxt = ((k_r >> 1) == AW'(1)) ? rmst_pkg::ST_IDLE : rmst_pkg::ST_UP_RD;
      end
      rmst_pkg::ST_Q_LO: begin
        state_nxt = (lo_r < hi_r) ? rmst_pkg::ST_Q_HI : rmst_pkg::ST_EMIT;
      end
      rmst_pkg::ST_Q_HI: state_nxt = rmst_pkg::ST_Q_LO;
      rmst_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = rmst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rmst_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    clr_nxt       = clr_r;
    k_nxt         = k_r;
    cur_nxt       = cur_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    best_nxt      = best_r;
    pend_nxt      = pend_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_max_nxt   = out_max_r;
    out_bad_nxt   = out_bad_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    unique case (state_r)
      rmst_pkg::ST_CLR: begin
        // Sweep zeros through every node
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + AW'(1);
      end
      rmst_pkg::ST_IDLE: begin
        if (!q_empty) begin
          unique case (q_cmd.op)
            rmst_pkg::OP_WRITE: begin
              // Write the leaf and start the climb from it
              wr_en   = 1'b1;
              wr_addr = AW'(leaf_idx);
              wr_data = q_cmd.value;
              k_nxt   = AW'(leaf_idx);
              cur_nxt = q_cmd.value;
            end
            rmst_pkg::OP_QUERY: begin
              lo_nxt   = q_lo;
              hi_nxt   = q_hi;
              best_nxt = '0;
              pend_nxt = 1'b0;
              bad_nxt  = 1'b0;
            end
            default: begin
              best_nxt = '0;
              pend_nxt = 1'b0;
              bad_nxt  = 1'b1;
            end
          endcase
        end
      end
      rmst_pkg::ST_UP_RD: begin
        // Fetch the sibling of the current node
        rd_en   = 1'b1;
        rd_addr = k_r ^ AW'(1);
      end
      rmst_pkg::ST_UP_WR: begin
        // Rewrite the parent with the larger child
        wr_en   = 1'b1;
        wr_addr = k_r >> 1;
        wr_data = up_max;
        cur_nxt = up_max;
        k_nxt   = k_r >> 1;
      end
      rmst_pkg::ST_Q_LO: begin
        best_nxt = acc;
        pend_nxt = 1'b0;
        if ((lo_r < hi_r) && lo_r[0]) begin
          rd_en    = 1'b1;
          rd_addr  = AW'(lo_r);
          lo_nxt   = lo_r + IW'(1);
          pend_nxt = 1'b1;
        end
      end
      rmst_pkg::ST_Q_HI: begin
        // Take the right edge node, then step both bounds up a level
        best_nxt = acc;
        pend_nxt = 1'b0;
        lo_nxt   = lo_r >> 1;
        hi_nxt   = hi_r >> 1;
        if (hi_r[0]) begin
          rd_en    = 1'b1;
          rd_addr  = AW'(hi_dec);
          hi_nxt   = hi_dec >> 1;
          pend_nxt = 1'b1;
        end
      end
      rmst_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_max_nxt   = best_r;
          out_bad_nxt   = bad_r;
        end
      end
      default: begin
        clr_nxt = clr_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmst_pkg::ST_CLR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    cur_r     <= cur_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    best_r    <= best_nxt;
    bad_r     <= bad_nxt;
    out_max_r <= out_max_nxt;
    out_bad_r <= out_bad_nxt;
  end

  // Node memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  `RMST_ASSERT_IMP(a_pop_idle, q_pop, !stat.clearing && state_r == rmst_pkg::ST_IDLE)
  `RMST_ASSERT_IMP(a_climb_above_root, state_r == rmst_pkg::ST_UP_RD, k_r > AW'(1))
  `RMST_ASSERT_NEXT(a_emit_loads, state_r == rmst_pkg::ST_EMIT && out_free, out_valid_r)
  `RMST_ASSERT_IMP(a_bad_zero, out_valid_r && out_bad_r, out_max_r == '0)

endmodule

FILE: hdl/range_max_segment_tree.sv
// Write: the leaf is written, then each tree level above it takes a sibling read and a parent write.
// Query: left-edge and right-edge steps per level, then the result register loads.
// One request runs in the back end at a time; the one node memory sets the pace.
// Bad-range queries go straight to the result register; ignored writes are dropped on acceptance.
// Reset (rst_n low, synchronous) starts a clearing pass over all 2*PAD nodes, in_tready low.
module range_max_segment_tree #(
  parameter int LEAVES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // position[9:0], range_end[20:10], value[51:21], zero pad
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // maximum[30:0], zero pad
  output logic        out_tuser   // bad_range
);

  rmst_pkg::cmd_t       push_cmd;
  rmst_pkg::cmd_t       head_cmd;
  rmst_pkg::back_stat_t stat;
  logic                 q_push;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_empty;

  rmst_front #(
    .LEAVES(LEAVES)
  ) u_front (
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_full   (q_full),
    .stat     (stat),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  rmst_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .head_cmd(head_cmd),
    .empty   (q_empty)
  );

  rmst_back #(
    .LEAVES(LEAVES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_cmd     (head_cmd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .stat      (stat),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

FILE: sim/tb_top.sv
// Self-checking stream testbench for the range maximum segment tree: writes and range queries.
`timescale 1ns / 100ps

module tb_top;

  localparam int   POS_W      = rmst_pkg::POS_W;
  localparam int   END_W      = rmst_pkg::END_W;
  localparam int   VAL_W      = rmst_pkg::VAL_W;
  localparam logic KIND_WRITE = rmst_pkg::KIND_WRITE;
  localparam logic KIND_QUERY = rmst_pkg::KIND_QUERY;

  localparam int LEAF_COUNT      = 1024;
  localparam int RANDOM_ITEMS    = 880;
  localparam int TAIL_CYCLES     = 60;
  localparam int WATCHDOG_LIMIT  = 12000;
  localparam int MAX_SHOWN_ERRS  = 10;

  // One request as driven on the input stream
  typedef struct {
    logic             kind;
    logic [POS_W-1:0] position;
    logic [END_W-1:0] range_end;
    logic [VAL_W-1:0] value;
    bit               wait_drain;
  } seg_req_t;

  // One query answer as seen on the output stream
  typedef struct {
    logic [VAL_W-1:0] maximum;
    logic             bad_range;
  } range_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;   // position[9:0], range_end[20:10], value[51:21], zero pad
  logic        in_tuser = 1'b0; // kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // maximum[30:0], zero pad
  logic        out_tuser;       // bad_range

  seg_req_t         pending_q[$];
  range_result_t    result_q[$];
  seg_req_t         cur_req;
  logic [VAL_W-1:0] leaf_val [LEAF_COUNT];

  int unsigned issue_cnt = 0;
  int unsigned accept_cnt = 0;
  int unsigned total_reqs = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned err_cnt = 0;
  int unsigned n_writes = 0;
  int unsigned n_queries = 0;
  int unsigned n_bad = 0;
  int unsigned n_checked = 0;

  range_max_segment_tree #(
    .LEAVES(LEAF_COUNT)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Gap length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_req(input logic kind, input int unsigned pos, input int unsigned stop,
                          input logic [VAL_W-1:0] val, input bit drain);
    seg_req_t req;
    req.kind       = kind;
    req.position   = pos[POS_W-1:0];
    req.range_end  = stop[END_W-1:0];
    req.value      = val;
    req.wait_drain = drain;
    pending_q.push_back(req);
  endtask

  task automatic log_error(input string msg);
    if (err_cnt < MAX_SHOWN_ERRS) $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Apply one accepted request to the leaf copy; queue the answer of a query
  task automatic predict_range_max(input seg_req_t req);
    range_result_t res;
    logic [VAL_W-1:0] best;
    if (req.kind == KIND_WRITE) begin
      n_writes++;
      if (req.position < LEAF_COUNT) leaf_val[req.position] = req.value;
    end else begin
      n_queries++;
      best = '0;
      if (req.position >= req.range_end || req.range_end > LEAF_COUNT) begin
        n_bad++;
        res.bad_range = 1'b1;
      end else begin
        res.bad_range = 1'b0;
        for (int i = int'(req.position); i < int'(req.range_end); i++) begin
          if (leaf_val[i] > best) best = leaf_val[i];
        end
      end
      res.maximum = best;
      result_q.push_back(res);
    end
  endtask

  // Request driver: hold until accepted, then gap or launch the next request
  always @(negedge clk) begin
    seg_req_t req;
    if (rst_n && accept_cnt == issue_cnt) begin
      if (gap_left != 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].wait_drain && result_q.size() != 0)) begin
        req = pending_q.pop_front();
        cur_req   <= req;
        in_tvalid <= 1'b1;
        in_tuser  <= req.kind;
        in_tdata  <= {4'b0, req.value, req.range_end, req.position};
        issue_cnt <= issue_cnt + 1;
        // long stretches without any sender gap
        gap_left  <= ((issue_cnt / 80) % 4 == 1) ? 0 : pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side backpressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_tready <= 1'b1;
        if ((n_checked / 20) % 4 != 1 && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
    end
  end

  // Monitor: check results, predict accepted requests, watch for a hang
  always @(posedge clk) begin
    range_result_t got;
    range_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.maximum   = out_tdata[VAL_W-1:0];
        got.bad_range = out_tuser;
        if (result_q.size() == 0) begin
          log_error($sformatf("unexpected result: maximum %0h bad_range %0b",
                              got.maximum, got.bad_range));
        end else begin
          want = result_q.pop_front();
          n_checked++;
          if (got.maximum !== want.maximum || got.bad_range !== want.bad_range) begin
            log_error($sformatf("result %0d: maximum exp %0h got %0h, bad_range exp %0b got %0b",
                                n_checked, want.maximum, got.maximum,
                                want.bad_range, got.bad_range));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_range_max(cur_req);
        accept_cnt <= accept_cnt + 1;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("range_max_segment_tree verification failed");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned pos;
    int unsigned stop;
    int unsigned r;
    logic [VAL_W-1:0] val;
    foreach (leaf_val[i]) leaf_val[i] = '0;

    // Directed: empty tree, bad ranges, field extremes, overwrite, drain pause
    push_req(KIND_QUERY, 0, LEAF_COUNT, '0, 0);
    push_req(KIND_QUERY, 0, 0, '0, 0);
    push_req(KIND_QUERY, 1023, 1023, '0, 0);
    push_req(KIND_QUERY, 5, 3, '0, 0);
    push_req(KIND_QUERY, 0, 1025, '0, 0);
    push_req(KIND_QUERY, 1023, 2047, '0, 0);
    push_req(KIND_WRITE, 0, 0, 31'h7FFF_FFFF, 0);
    push_req(KIND_WRITE, 1023, 2047, 31'h1, 0);
    push_req(KIND_WRITE, 512, 0, 31'h2AAA_AAAA, 0);
    push_req(KIND_WRITE, 511, 0, 31'h5555_5555, 0);
    push_req(KIND_QUERY, 0, 1, '0, 0);
    push_req(KIND_QUERY, 1, LEAF_COUNT, '0, 0);
    push_req(KIND_QUERY, 1023, LEAF_COUNT, '0, 0);
    push_req(KIND_QUERY, 512, 1023, '0, 0);
    push_req(KIND_QUERY, 1, 511, '0, 0);
    push_req(KIND_QUERY, 511, 513, '0, 0);
    push_req(KIND_QUERY, 0, LEAF_COUNT, '0, 0);
    push_req(KIND_WRITE, 0, 0, '0, 0);
    push_req(KIND_QUERY, 0, 1, '0, 0);
    push_req(KIND_QUERY, 0, 511, '0, 1);
    push_req(KIND_QUERY, 0, LEAF_COUNT, '0, 0);

    // Random mix of writes and queries, with an occasional drain pause
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        pos = ($urandom_range(0, 9) < 3) ? ($urandom_range(0, 1) ? $urandom_range(0, 31)
                                                                  : $urandom_range(992, 1023))
                                         : $urandom_range(0, 1023);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: val = VAL_W'($urandom());
          5, 6, 7:       val = VAL_W'($urandom_range(0, 1000));
          8:             val = '0;
          default:       val = 31'h7FFF_FFFF;
        endcase
        push_req(KIND_WRITE, pos, $urandom_range(0, 2047), val, (n % 150) == 149);
      end else begin
        pos = $urandom_range(0, 1023);
        if (r < 50) stop = $urandom_range(0, pos);
        else if (r < 55) stop = $urandom_range(1025, 2047);
        else if (r < 58) begin
          pos  = 0;
          stop = LEAF_COUNT;
        end else if (r < 80) stop = (pos + 1 + $urandom_range(0, 15) > LEAF_COUNT) ?
                                    LEAF_COUNT : pos + 1 + $urandom_range(0, 15);
        else stop = $urandom_range(pos + 1, LEAF_COUNT);
        push_req(KIND_QUERY, pos, stop, VAL_W'($urandom()), (n % 150) == 149);
      end
    end
    total_reqs = pending_q.size();

    // Hold reset low, then release it on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accept_cnt != total_reqs) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d writes and %0d queries (%0d with a bad range), %0d answers checked",
             n_writes, n_queries, n_bad, n_checked);
    $display("under random gaps on both streams, including a full drain before a request");
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("range_max_segment_tree verification clean");
    end else begin
      $display("range_max_segment_tree verification failed");
    end
    $finish;
  end

endmodule

FILE: range_max_segment_tree.f
+incdir+hdl
hdl/rmst_pkg.sv
hdl/rmst_front.sv
hdl/rmst_fifo.sv
hdl/rmst_back.sv
hdl/range_max_segment_tree.sv
sim/tb_top.sv
